// ===== rtl/core/gcr_pkg.sv =====
// Shared types, constants and register indexes for the glyph column renderer.
package gcr_pkg;

   localparam int FIELD_COORD_W    = 9;
   localparam int COORD_WIDTH_DEF  = 9;
   localparam int COLOR_W          = 16;
   localparam int CELL_H_W         = 5;
   localparam int GLYPH_W          = 8;
   localparam int BIT_IDX_W        = 3;
   localparam int CSR_INDEX_W      = 2;
   localparam int REQ_DEPTH_DEF    = 2;
   localparam int RSP_DEPTH_DEF    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FG_COLOR       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_COLOR       = 2'd3;

   localparam logic [FIELD_COORD_W-1:0] DISPLAY_WIDTH_RST  = 9'd320;
   localparam logic [FIELD_COORD_W-1:0] DISPLAY_HEIGHT_RST = 9'd240;
   localparam logic [COLOR_W-1:0]       FG_COLOR_RST       = 16'h0000;
   localparam logic [COLOR_W-1:0]       BG_COLOR_RST       = 16'hFFFF;
   localparam logic [CELL_H_W-1:0]      CELL_H_RST         = 5'd16;

   localparam logic [GLYPH_W-1:0] GLYPH_MSB_MASK = 8'h80;

   typedef struct packed {
      logic [FIELD_COORD_W-1:0] display_width;
      logic [FIELD_COORD_W-1:0] display_height;
      logic [COLOR_W-1:0]       fg_color;
      logic [COLOR_W-1:0]       bg_color;
   } cfg_type;

   typedef struct packed {
      logic                     first_byte;
      logic [FIELD_COORD_W-1:0] origin_x;
      logic [FIELD_COORD_W-1:0] origin_y;
      logic [CELL_H_W-1:0]      cell_height;
      logic                     transparent;
      logic [GLYPH_W-1:0]       glyph_byte;
   } req_item_type;

   typedef struct packed {
      logic [FIELD_COORD_W-1:0] pix_x;
      logic [FIELD_COORD_W-1:0] pix_y;
      logic [COLOR_W-1:0]       pix_color;
      logic                     run_last;
      logic                     edge_stop;
   } pix_item_type;

endpackage

// ===== rtl/core/glyph_column_renderer_top.sv =====
// Top level of the glyph column renderer: config registers, queues and pixel engine.
// Each font byte is fetched from the input queue, then the pixel engine walks its
// bits one per cycle while it is not waiting (up to eight, fewer when the column or
// the display edge ends the byte), and a flush state releases the byte's last pixel
// write when the byte wrote any pixel; a transparent byte that writes none goes back
// to idle, and a byte dropped after a stop or before any first byte is only popped.
// The engine waits whenever it has a pixel to hand over and the result queue is full.
// Configuration writes are taken every cycle (csr_ready is high).
module glyph_column_renderer_top
   import gcr_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int REQ_DEPTH   = REQ_DEPTH_DEF,
   parameter int RSP_DEPTH   = RSP_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic                     req_first_byte,
   input  logic [FIELD_COORD_W-1:0] req_origin_x,
   input  logic [FIELD_COORD_W-1:0] req_origin_y,
   input  logic [CELL_H_W-1:0]      req_cell_height,
   input  logic                     req_transparent,
   input  logic [GLYPH_W-1:0]       req_glyph_byte,
   output logic                     empty,
   input  logic                     pop,
   output logic [FIELD_COORD_W-1:0] rsp_pix_x,
   output logic [FIELD_COORD_W-1:0] rsp_pix_y,
   output logic [COLOR_W-1:0]       rsp_pix_color,
   output logic                     rsp_run_last,
   output logic                     rsp_edge_stop,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [COLOR_W-1:0]       csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   req_item_type req_item, eng_in_item;
   pix_item_type eng_out_item, rsp_item;
   logic         eng_in_empty, eng_in_pop, eng_out_full, eng_out_push;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DISPLAY_WIDTH:  cfg_in.display_width  = csr_wdata[FIELD_COORD_W-1:0];
            CSR_DISPLAY_HEIGHT: cfg_in.display_height = csr_wdata[FIELD_COORD_W-1:0];
            CSR_FG_COLOR:       cfg_in.fg_color       = csr_wdata;
            CSR_BG_COLOR:       cfg_in.bg_color       = csr_wdata;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_width  <= DISPLAY_WIDTH_RST;
         cfg_ff.display_height <= DISPLAY_HEIGHT_RST;
         cfg_ff.fg_color       <= FG_COLOR_RST;
         cfg_ff.bg_color       <= BG_COLOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_item.first_byte  = req_first_byte;
      req_item.origin_x    = req_origin_x;
      req_item.origin_y    = req_origin_y;
      req_item.cell_height = req_cell_height;
      req_item.transparent = req_transparent;
      req_item.glyph_byte  = req_glyph_byte;
   end

   gcr_fifo #(
      .WIDTH ($bits(req_item_type)),
      .DEPTH (REQ_DEPTH)
   ) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (req_item),
      .full      (full),
      .pop       (eng_in_pop),
      .pop_data  (eng_in_item),
      .empty     (eng_in_empty)
   );

   gcr_pixel_engine #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_pixel_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_empty (eng_in_empty),
      .in_item  (eng_in_item),
      .in_pop   (eng_in_pop),
      .out_full (eng_out_full),
      .out_push (eng_out_push),
      .out_item (eng_out_item)
   );

   gcr_fifo #(
      .WIDTH ($bits(pix_item_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_out_push),
      .push_data (eng_out_item),
      .full      (eng_out_full),
      .pop       (pop),
      .pop_data  (rsp_item),
      .empty     (empty)
   );

   assign rsp_pix_x     = rsp_item.pix_x;
   assign rsp_pix_y     = rsp_item.pix_y;
   assign rsp_pix_color = rsp_item.pix_color;
   assign rsp_run_last  = rsp_item.run_last;
   assign rsp_edge_stop = rsp_item.edge_stop;

endmodule

// ===== rtl/core/gcr_fifo.sv =====
// Small register-based queue used between the ports and the pixel engine.
module gcr_fifo
   import gcr_pkg::*;
#(
   parameter int WIDTH = $bits(req_item_type),
   parameter int DEPTH = REQ_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/gcr_pixel_engine.sv =====
// Back end: walks font bytes one bit per cycle unless stalled; emits pixels.
module gcr_pixel_engine
   import gcr_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_empty,
   input  req_item_type in_item,
   output logic         in_pop,
   input  logic         out_full,
   output logic         out_push,
   output pix_item_type out_item
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   localparam int CW = COORD_WIDTH;

   state_type                state_ff, state_in;
   logic [CW-1:0]            cur_col_ff, cur_col_in;
   logic [CW-1:0]            cur_row_ff, cur_row_in;
   logic [CW-1:0]            top_row_ff, top_row_in;
   logic [CELL_H_W-1:0]      cell_h_ff, cell_h_in;
   logic                     mode_t_ff, mode_t_in;
   logic                     halted_ff, halted_in;
   logic [GLYPH_W-1:0]       shift_ff, shift_in;
   logic [BIT_IDX_W-1:0]     idx_ff, idx_in;
   logic                     pend_valid_ff, pend_valid_in;
   pix_item_type             pend_ff, pend_in;

   logic [CW:0]              ny, nx, row_diff, dw_ext, dh_ext;
   logic                     bit_set, emit, stop_row, col_hit, stop_col, stop;
   logic                     col_end, done, stall, next_halted;
   pix_item_type             cur_pix;

   always_comb begin
      ny       = {1'b0, cur_row_ff} + 1'b1;
      nx       = {1'b0, cur_col_ff} + 1'b1;
      row_diff = ny - {1'b0, top_row_ff};
      dw_ext   = (CW + 1)'(cfg.display_width);
      dh_ext   = (CW + 1)'(cfg.display_height);
      bit_set  = |(shift_ff & GLYPH_MSB_MASK);
      emit     = bit_set | ~mode_t_ff;
      stop_row = (ny >= dh_ext);
      col_hit  = (row_diff == (CW + 1)'(cell_h_ff));
      col_end  = ~stop_row & col_hit;
      stop_col = col_end & (nx >= dw_ext);
      stop     = stop_row | stop_col;
      done     = stop | col_end | (idx_ff == BIT_IDX_W'(GLYPH_W - 1));
      stall    = emit & pend_valid_ff & out_full;

      cur_pix.pix_x     = FIELD_COORD_W'(cur_col_ff);
      cur_pix.pix_y     = FIELD_COORD_W'(cur_row_ff);
      cur_pix.pix_color = bit_set ? cfg.fg_color : cfg.bg_color;
      cur_pix.run_last  = 1'b0;
      cur_pix.edge_stop = stop;
   end

   always_comb begin
      state_in      = state_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      top_row_in    = top_row_ff;
      cell_h_in     = cell_h_ff;
      mode_t_in     = mode_t_ff;
      halted_in     = halted_ff;
      shift_in      = shift_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      next_halted   = halted_ff;
      in_pop        = 1'b0;
      out_push      = 1'b0;
      out_item      = pend_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!in_empty) begin
               in_pop = 1'b1;
               if (in_item.first_byte) begin
                  cur_col_in  = CW'(in_item.origin_x);
                  cur_row_in  = CW'(in_item.origin_y);
                  top_row_in  = CW'(in_item.origin_y);
                  cell_h_in   = in_item.cell_height;
                  mode_t_in   = in_item.transparent;
                  halted_in   = 1'b0;
                  next_halted = 1'b0;
               end
               if (!next_halted) begin
                  shift_in = in_item.glyph_byte;
                  idx_in   = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (!stall) begin
               if (emit) begin
                  if (pend_valid_ff) begin
                     out_push = 1'b1;
                  end
                  pend_in       = cur_pix;
                  pend_valid_in = 1'b1;
               end
               if (stop_row) begin
                  halted_in = 1'b1;
               end else begin
                  cur_row_in = ny[CW-1:0];
                  if (col_hit) begin
                     cur_row_in = top_row_ff;
                     if (stop_col) begin
                        halted_in = 1'b1;
                     end else begin
                        cur_col_in = nx[CW-1:0];
                     end
                  end
               end
               shift_in = {shift_ff[GLYPH_W-2:0], 1'b0};
               idx_in   = idx_ff + 1'b1;
               if (done) begin
                  state_in = (emit | pend_valid_ff) ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (!out_full) begin
               out_push          = 1'b1;
               out_item.run_last = 1'b1;
               pend_valid_in     = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         top_row_ff    <= '0;
         cell_h_ff     <= CELL_H_RST;
         mode_t_ff     <= 1'b0;
         halted_ff     <= 1'b1;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         top_row_ff    <= top_row_in;
         cell_h_ff     <= cell_h_in;
         mode_t_ff     <= mode_t_in;
         halted_ff     <= halted_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
      end
      shift_ff <= shift_in;
      pend_ff  <= pend_in;
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending pixel left over in idle");

   a_flush_has_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> pend_valid_ff)
      else $error("flush without a pending pixel");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("pixel pushed into a full queue");

   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && !stall && stop) |=> halted_ff && (state_ff != ST_RUN))
      else $error("edge stop did not halt the character");

endmodule

// ===== test/glyph_column_renderer_top_test.sv =====
// Self-checking testbench for the glyph column renderer: directed and random font bytes.
`timescale 1ns / 1ps

module glyph_column_renderer_top_test;
   import gcr_pkg::*;

   localparam int SETTLE      = 40;
   localparam int TIMEOUT     = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int RAND_BYTES  = 204;
   localparam int PHASES      = 6;

   typedef struct {
      bit                       is_reg;
      logic [CSR_INDEX_W-1:0]   reg_idx;
      logic [COLOR_W-1:0]       reg_data;
      req_item_type             item;
      int                       golden_n;
      pix_item_type             golden;
   } plan_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     push = 1'b0;
   logic                     full;
   logic                     req_first_byte = 1'b0;
   logic [FIELD_COORD_W-1:0] req_origin_x = '0;
   logic [FIELD_COORD_W-1:0] req_origin_y = '0;
   logic [CELL_H_W-1:0]      req_cell_height = '0;
   logic                     req_transparent = 1'b0;
   logic [GLYPH_W-1:0]       req_glyph_byte = '0;
   logic                     empty;
   logic                     pop = 1'b0;
   logic [FIELD_COORD_W-1:0] rsp_pix_x;
   logic [FIELD_COORD_W-1:0] rsp_pix_y;
   logic [COLOR_W-1:0]       rsp_pix_color;
   logic                     rsp_run_last;
   logic                     rsp_edge_stop;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [COLOR_W-1:0]       csr_wdata = '0;

   // drawing model state
   cfg_type                  panel_cfg;
   logic [FIELD_COORD_W-1:0] col_q, row_q, top_q;
   logic [CELL_H_W-1:0]      cell_h_q;
   logic                     transp_q, halted_q;

   pix_item_type pending_pixels[$];
   plan_row_type plan[$];

   int  mismatches = 0;
   int  bytes_sent = 0;
   int  reg_writes = 0;
   int  pixels_seen = 0;
   int  stops_seen = 0;
   int  burst_left = 0;
   bit  calm = 1'b0;
   bit  hold_off_req = 1'b0;

   always #5 clock = ~clock;

   glyph_column_renderer_top uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_first_byte(req_first_byte),
      .req_origin_x(req_origin_x),
      .req_origin_y(req_origin_y),
      .req_cell_height(req_cell_height),
      .req_transparent(req_transparent),
      .req_glyph_byte(req_glyph_byte),
      .empty(empty),
      .pop(pop),
      .rsp_pix_x(rsp_pix_x),
      .rsp_pix_y(rsp_pix_y),
      .rsp_pix_color(rsp_pix_color),
      .rsp_run_last(rsp_run_last),
      .rsp_edge_stop(rsp_edge_stop),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   function automatic pix_item_type pix(int x, int y, int c, bit last, bit stop);
      pix_item_type p;
      p.pix_x     = x[FIELD_COORD_W-1:0];
      p.pix_y     = y[FIELD_COORD_W-1:0];
      p.pix_color = c[COLOR_W-1:0];
      p.run_last  = last;
      p.edge_stop = stop;
      return p;
   endfunction

   function automatic plan_row_type mk_byte(bit first, int x, int y, int h, bit tr, int g,
                                            int golden_n = -1, pix_item_type golden = '0);
      plan_row_type r;
      r.is_reg           = 1'b0;
      r.reg_idx          = '0;
      r.reg_data         = '0;
      r.item.first_byte  = first;
      r.item.origin_x    = x[FIELD_COORD_W-1:0];
      r.item.origin_y    = y[FIELD_COORD_W-1:0];
      r.item.cell_height = h[CELL_H_W-1:0];
      r.item.transparent = tr;
      r.item.glyph_byte  = g[GLYPH_W-1:0];
      r.golden_n         = golden_n;
      r.golden           = golden;
      return r;
   endfunction

   function automatic plan_row_type mk_reg(logic [CSR_INDEX_W-1:0] idx, int data);
      plan_row_type r;
      r          = mk_byte(1'b0, 0, 0, 0, 1'b0, 0);
      r.is_reg   = 1'b1;
      r.reg_idx  = idx;
      r.reg_data = data[COLOR_W-1:0];
      return r;
   endfunction

   function automatic req_item_type random_byte();
      req_item_type it;
      it.first_byte  = 1'($urandom_range(0, 1));
      it.origin_x    = FIELD_COORD_W'($urandom_range(0, 511));
      it.origin_y    = FIELD_COORD_W'($urandom_range(0, 511));
      it.cell_height = CELL_H_W'($urandom_range(0, 31));
      it.transparent = 1'($urandom_range(0, 1));
      it.glyph_byte  = GLYPH_W'($urandom_range(0, 255));
      return it;
   endfunction

   // Walk one font byte down the current column; drop it while the character is halted.
   function automatic void render_byte(req_item_type it, bit keep);
      pix_item_type     p;
      pix_item_type     run[$];
      logic [GLYPH_W-1:0] bits;
      int unsigned      ny, nx;
      bit               set, stop, col_end;
      bits = it.glyph_byte;
      if (it.first_byte) begin
         col_q    = it.origin_x;
         row_q    = it.origin_y;
         top_q    = it.origin_y;
         cell_h_q = it.cell_height;
         transp_q = it.transparent;
         halted_q = 1'b0;
      end
      if (halted_q)
         return;
      for (int b = 0; b < GLYPH_W; b++) begin
         set     = bits[GLYPH_W-1];
         bits    = bits << 1;
         stop    = 1'b0;
         col_end = 1'b0;
         p.pix_x = col_q;
         p.pix_y = row_q;
         ny      = row_q + 1;
         if (ny >= panel_cfg.display_height) begin
            stop = 1'b1;
         end else begin
            row_q = ny[FIELD_COORD_W-1:0];
            if (ny - top_q == cell_h_q) begin
               row_q   = top_q;
               col_end = 1'b1;
               nx      = col_q + 1;
               if (nx >= panel_cfg.display_width)
                  stop = 1'b1;
               else
                  col_q = nx[FIELD_COORD_W-1:0];
            end
         end
         if (set || !transp_q) begin
            p.pix_color = set ? panel_cfg.fg_color : panel_cfg.bg_color;
            p.run_last  = 1'b0;
            p.edge_stop = stop;
            run.push_back(p);
         end
         if (stop) begin
            halted_q = 1'b1;
            break;
         end
         if (col_end)
            break;
      end
      if (run.size() > 0) begin
         p          = run[run.size()-1];
         p.run_last = 1'b1;
         run[run.size()-1] = p;
      end
      if (keep)
         foreach (run[i]) pending_pixels.push_back(run[i]);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic pace();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap = calm ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic push_item(input req_item_type it, input int golden_n,
                            input pix_item_type golden);
      csr_valid       <= 1'b0;
      push            <= 1'b1;
      req_first_byte  <= it.first_byte;
      req_origin_x    <= it.origin_x;
      req_origin_y    <= it.origin_y;
      req_cell_height <= it.cell_height;
      req_transparent <= it.transparent;
      req_glyph_byte  <= it.glyph_byte;
      do @(posedge clock); while (full);
      render_byte(it, golden_n < 0);
      if (golden_n == 1)
         pending_pixels.push_back(golden);
      bytes_sent++;
      pace();
   endtask

   // Hold until every pixel has drained and trailing bytes are flushed.
   task automatic settle();
      push <= 1'b0;
      while (pending_pixels.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [COLOR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DISPLAY_WIDTH:  panel_cfg.display_width  = data[FIELD_COORD_W-1:0];
         CSR_DISPLAY_HEIGHT: panel_cfg.display_height = data[FIELD_COORD_W-1:0];
         CSR_FG_COLOR:       panel_cfg.fg_color       = data;
         CSR_BG_COLOR:       panel_cfg.bg_color       = data;
         default: ;
      endcase
      reg_writes++;
   endtask

   function automatic int pick_extent();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 1;
         2: return 511;
         default: return $urandom_range(16, 511);
      endcase
   endfunction

   function automatic int pick_color();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 16'hFFFF;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   always @(posedge clock) begin : pixel_check
      pix_item_type want;
      if (!reset && pop && !empty) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t ns: pixel write expected none actual x=%0d y=%0d color=%0h",
                     $time, rsp_pix_x, rsp_pix_y, rsp_pix_color);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pix_x", want.pix_x, rsp_pix_x);
            check_field("pix_y", want.pix_y, rsp_pix_y);
            check_field("pix_color", want.pix_color, rsp_pix_color);
            check_field("run_last", want.run_last, rsp_run_last);
            check_field("edge_stop", want.edge_stop, rsp_edge_stop);
            pixels_seen++;
            if (rsp_edge_stop)
               stops_seen++;
         end
      end
   end

   initial begin : pixel_sink
      int rx_mode;
      int rx_left;
      rx_mode = 0;
      rx_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            pop <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = $urandom_range(0, 2);
               rx_left = $urandom_range(8, 64);
            end
            rx_left--;
            case (rx_mode)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(0, 1));
               default: pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      repeat (TIMEOUT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      req_item_type it;
      bit           prev_reg;
      int           placed;
      int           n_cont;

      panel_cfg.display_width  = DISPLAY_WIDTH_RST;
      panel_cfg.display_height = DISPLAY_HEIGHT_RST;
      panel_cfg.fg_color       = FG_COLOR_RST;
      panel_cfg.bg_color       = BG_COLOR_RST;
      col_q    = '0;
      row_q    = '0;
      top_q    = '0;
      cell_h_q = CELL_H_RST;
      transp_q = 1'b0;
      halted_q = 1'b1;

      // reset register values
      plan.push_back(mk_byte(0, 5, 5, 8, 0, 8'hFF, 0));
      plan.push_back(mk_byte(1, 0, 0, 1, 0, 8'h80, 1, pix(0, 0, 16'h0000, 1, 0)));
      plan.push_back(mk_byte(0, 0, 0, 0, 0, 8'h00, 1, pix(1, 0, 16'hFFFF, 1, 0)));
      plan.push_back(mk_byte(1, 10, 20, 16, 0, 8'hA5));
      plan.push_back(mk_byte(0, 0, 0, 0, 0, 8'h5A));
      plan.push_back(mk_byte(0, 0, 0, 0, 0, 8'hFF));
      plan.push_back(mk_byte(0, 0, 0, 0, 0, 8'h00));
      plan.push_back(mk_byte(1, 100, 50, 12, 1, 8'hFF));
      plan.push_back(mk_byte(0, 0, 0, 0, 0, 8'h0F));
      plan.push_back(mk_byte(0, 0, 0, 0, 0, 8'hF0));
      plan.push_back(mk_byte(1, 0, 230, 0, 0, 8'h3C));
      plan.push_back(mk_byte(0, 0, 0, 0, 0, 8'hC3));
      plan.push_back(mk_byte(0, 0, 0, 0, 0, 8'hFF, 0));
      plan.push_back(mk_byte(1, 511, 511, 16, 0, 8'h80, 1, pix(511, 511, 16'h0000, 1, 1)));
      plan.push_back(mk_byte(1, 400, 0, 1, 0, 8'h00, 1, pix(400, 0, 16'hFFFF, 1, 1)));
      plan.push_back(mk_byte(1, 0, 239, 16, 1, 8'h7F, 0));
      plan.push_back(mk_byte(0, 0, 0, 0, 0, 8'hFF, 0));
      plan.push_back(mk_byte(1, 319, 0, 2, 0, 8'hC0));
      plan.push_back(mk_byte(1, 200, 100, 31, 1, 8'hAA));
      // zero width, tallest panel, extreme colors
      plan.push_back(mk_reg(CSR_DISPLAY_WIDTH, 0));
      plan.push_back(mk_reg(CSR_DISPLAY_HEIGHT, 511));
      plan.push_back(mk_reg(CSR_FG_COLOR, 16'hFFFF));
      plan.push_back(mk_reg(CSR_BG_COLOR, 16'h0000));
      plan.push_back(mk_byte(1, 0, 0, 1, 0, 8'h80, 1, pix(0, 0, 16'hFFFF, 1, 1)));
      plan.push_back(mk_byte(1, 3, 509, 16, 0, 8'h40));
      // zero height, then one row
      plan.push_back(mk_reg(CSR_DISPLAY_WIDTH, 511));
      plan.push_back(mk_reg(CSR_DISPLAY_HEIGHT, 0));
      plan.push_back(mk_byte(1, 0, 0, 8, 1, 8'h80, 1, pix(0, 0, 16'hFFFF, 1, 1)));
      plan.push_back(mk_reg(CSR_DISPLAY_HEIGHT, 1));
      plan.push_back(mk_byte(1, 510, 0, 1, 0, 8'h00, 1, pix(510, 0, 16'h0000, 1, 1)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      prev_reg = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            if (!prev_reg)
               settle();
            write_reg(plan[i].reg_idx, plan[i].reg_data);
         end else begin
            push_item(plan[i].item, plan[i].golden_n, plan[i].golden);
         end
         prev_reg = plan[i].is_reg;
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         if (phase == 1) begin
            write_reg(CSR_DISPLAY_WIDTH, 16'hFE00 | 16'd511);
            write_reg(CSR_DISPLAY_HEIGHT, 16'd511);
            write_reg(CSR_FG_COLOR, 16'h0000);
            write_reg(CSR_BG_COLOR, 16'hFFFF);
         end else begin
            write_reg(CSR_DISPLAY_WIDTH,
                      COLOR_W'(($urandom_range(0, 127) << FIELD_COORD_W) | pick_extent()));
            write_reg(CSR_DISPLAY_HEIGHT,
                      COLOR_W'(($urandom_range(0, 127) << FIELD_COORD_W) | pick_extent()));
            write_reg(CSR_FG_COLOR, COLOR_W'(pick_color()));
            write_reg(CSR_BG_COLOR, COLOR_W'(pick_color()));
         end
         calm = ($urandom_range(0, 3) == 0);
         if (phase == 0)
            hold_off_req = 1'b1;
         placed = 0;
         while (placed < RAND_BYTES / PHASES) begin
            it = random_byte();
            if ($urandom_range(0, 9) < 8) begin
               it.first_byte = 1'b1;
               if ($urandom_range(0, 7) != 0) begin
                  it.origin_x = FIELD_COORD_W'($urandom_range(0,
                                   panel_cfg.display_width > 0 ?
                                   panel_cfg.display_width - 1 : 0));
                  it.origin_y = FIELD_COORD_W'($urandom_range(0,
                                   panel_cfg.display_height > 0 ?
                                   panel_cfg.display_height - 1 : 0));
               end
               case ($urandom_range(0, 5))
                  0: it.cell_height = CELL_H_W'($urandom_range(0, 31));
                  1: it.cell_height = CELL_H_W'(8);
                  2: it.cell_height = CELL_H_W'(12);
                  default: it.cell_height = CELL_H_W'(16);
               endcase
               push_item(it, -1, '0);
               placed++;
               n_cont = $urandom_range(0, 5);
               repeat (n_cont) begin
                  it = random_byte();
                  it.first_byte = 1'b0;
                  push_item(it, -1, '0);
                  placed++;
               end
            end else begin
               push_item(it, -1, '0);
               placed++;
            end
         end
      end

      settle();
      if (pending_pixels.size() != 0) begin
         $display("%0t ns: %0d pixel writes expected but never seen", $time,
                  pending_pixels.size());
         mismatches++;
      end
      $display("Drew %0d font bytes under %0d register writes; %0d pixel writes checked.",
               bytes_sent, reg_writes, pixels_seen);
      $display("%0d characters ended at a panel edge; one long result hold-off applied.",
               stops_seen);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
